// File: hdl/c8sl_pkg.sv
// ----------------------------------------------------------------------------
// c8sl_pkg
// shared widths, codes and the crc-8 helper for the framed serial command link
// ----------------------------------------------------------------------------
package c8sl_pkg;

    localparam int CMD_W   = 24;
    localparam int FRAME_W = 32;
    localparam int POS_W   = 5;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_W - 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_BIT  = 1'b1;

    typedef logic [FRAME_W-1:0] frame_t;

    // one byte through the crc, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic frame_t build_frame(input logic [CMD_W-1:0] cmd);
        logic [7:0] crc;
        crc = crc8_byte(8'h00, cmd[7:0]);
        crc = crc8_byte(crc, cmd[15:8]);
        crc = crc8_byte(crc, cmd[23:16]);
        return {cmd[7:0], cmd[15:8], cmd[23:16], crc};
    endfunction

endpackage

// File: hdl/crc8_framed_serial_command_link_top.sv
// ----------------------------------------------------------------------------
// crc8_framed_serial_command_link_top
// serial command master: builds a crc-8 framed 32-bit frame from a 24-bit
// command and exchanges it one bit per request, msb first
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes requests. s_tuser selects load (0) or bit exchange (1).
//   a load carries the command in s_tdata, a bit exchange the sampled data-in
//   line. every request gives exactly one result on the m_ channel: the next
//   data-out bit, the received word with m_tlast on the 32nd bit, and
//   m_tuser set for a bit request that arrives with no frame in progress.
// registering and throughput:
//   the result is registered in the cycle after the request is taken; one request
//   per cycle is sustained with m_tready high, set by the single result register.
// reset:
//   aresetn low clears the frame state to idle and empties the result
//   register.
// stall:
//   while m_tready is low and a result is held, s_tready drops; once the
//   result is taken a new request is accepted in the same cycle.
// ----------------------------------------------------------------------------
module crc8_framed_serial_command_link_top
    import c8sl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // command [23:0], miso_bit [24], zero pad
    input  logic                s_tuser,   // kind [0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // mosi_bit [0], rx_word [32:1], zero pad
    output logic                m_tlast,   // frame_done
    output logic                m_tuser    // idle_error [0]
);

    frame_t           tx_frame_reg, tx_frame_next;
    frame_t           rx_shift_reg, rx_shift_next;
    logic [POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic             active_reg, active_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_mosi_reg, m_mosi_next;
    logic             m_done_reg, m_done_next;
    frame_t           m_word_reg, m_word_next;
    logic             m_err_reg, m_err_next;

    logic             s_accept;
    logic [CMD_W-1:0] cmd;
    logic             miso;
    logic [POS_W-1:0] pos_dec;
    frame_t           rx_set;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cmd      = s_tdata[CMD_W-1:0];
    assign miso     = s_tdata[CMD_W];
    assign pos_dec  = bit_pos_reg - POS_W'(1);

    always_comb begin
        rx_set = rx_shift_reg;
        rx_set[bit_pos_reg] = miso;
    end

    always_comb begin
        tx_frame_next = tx_frame_reg;
        rx_shift_next = rx_shift_reg;
        bit_pos_next  = bit_pos_reg;
        active_next   = active_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_mosi_next   = m_mosi_reg;
        m_done_next   = m_done_reg;
        m_word_next   = m_word_reg;
        m_err_next    = m_err_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
            m_mosi_next  = 1'b0;
            m_done_next  = 1'b0;
            m_word_next  = '0;
            m_err_next   = 1'b0;
            case (s_tuser)
                KIND_LOAD: begin
                    tx_frame_next = build_frame(cmd);
                    rx_shift_next = '0;
                    bit_pos_next  = LAST_POS;
                    active_next   = 1'b1;
                    m_mosi_next   = cmd[7];
                end
                KIND_BIT: begin
                    if (!active_reg) begin
                        m_err_next = 1'b1;
                    end else begin
                        rx_shift_next = rx_set;
                        if (bit_pos_reg == '0) begin
                            m_done_next = 1'b1;
                            m_word_next = rx_set;
                            active_next = 1'b0;
                        end else begin
                            bit_pos_next = pos_dec;
                            m_mosi_next  = tx_frame_reg[pos_dec];
                        end
                    end
                end
                default: begin
                    m_err_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_frame_reg <= '0;
            rx_shift_reg <= '0;
            bit_pos_reg  <= '0;
            active_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            tx_frame_reg <= tx_frame_next;
            rx_shift_reg <= rx_shift_next;
            bit_pos_reg  <= bit_pos_next;
            active_reg   <= active_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_mosi_reg <= m_mosi_next;
        m_done_reg <= m_done_next;
        m_word_reg <= m_word_next;
        m_err_reg  <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - FRAME_W - 1){1'b0}}, m_word_reg, m_mosi_reg};
    assign m_tlast  = m_done_reg;
    assign m_tuser  = m_err_reg;

endmodule

// File: tb/crc8_framed_serial_command_link_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_serial_command_link_top_test
// checks every result of the framed serial command link against a predictor
// that builds the crc-8 frame bit by bit and tracks the exchange position.
// loads and bit exchanges are streamed with random gaps on both channels,
// full frames most of the time, with broken frames, restarts and idle bits.
// ----------------------------------------------------------------------------
module crc8_framed_serial_command_link_top_test
    import c8sl_pkg::*;
();

    localparam int NUM_REQUESTS = 1850;
    localparam int STUCK_LIMIT  = 5000;

    typedef struct packed {
        logic             kind;
        logic [CMD_W-1:0] cmd;
        logic             miso;
    } link_request_t;

    typedef struct packed {
        logic         mosi;
        logic         done;
        logic [31:0]  word;
        logic         err;
    } link_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    link_request_t pending_requests[$];
    link_result_t  expected_results[$];
    link_request_t next_request;
    link_result_t  got_result;
    link_result_t  want_result;

    // predictor state
    frame_t          frame_bits = '0;
    logic [31:0]     rx_bits = '0;
    logic [POS_W-1:0] bit_pos = '0;
    logic            busy = 1'b0;

    int n_accepted = 0;
    int errors_seen = 0;
    int stuck_cycles = 0;
    logic steady_run;

    assign steady_run = (n_accepted >= 700) && (n_accepted < 1000);

    crc8_framed_serial_command_link_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // crc-8 shifted one message bit at a time, bytes low to high
    function automatic frame_t framed_command(input logic [CMD_W-1:0] cmd);
        logic [7:0] crc;
        logic [7:0] byte_val;
        logic       fb;
        crc = 8'h00;
        for (int b = 0; b < 3; b++) begin
            byte_val = cmd[8*b +: 8];
            for (int k = 7; k >= 0; k--) begin
                fb = crc[7] ^ byte_val[k];
                crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
        end
        return {cmd[7:0], cmd[15:8], cmd[23:16], crc};
    endfunction

    function automatic void predict_exchange(input link_request_t req);
        link_result_t r;
        r = '0;
        if (req.kind == KIND_LOAD) begin
            frame_bits = framed_command(req.cmd);
            rx_bits = '0;
            bit_pos = LAST_POS;
            busy = 1'b1;
            r.mosi = frame_bits[LAST_POS];
        end else if (!busy) begin
            r.err = 1'b1;
        end else begin
            rx_bits[bit_pos] = req.miso;
            if (bit_pos == '0) begin
                r.done = 1'b1;
                r.word = rx_bits;
                busy = 1'b0;
            end else begin
                bit_pos = bit_pos - POS_W'(1);
                r.mosi = frame_bits[bit_pos];
            end
        end
        expected_results.push_back(r);
    endfunction

    task automatic add_load(input logic [CMD_W-1:0] cmd);
        link_request_t req;
        req.kind = KIND_LOAD;
        req.cmd = cmd;
        req.miso = 1'($urandom_range(1));
        pending_requests.push_back(req);
    endtask

    task automatic add_bit(input logic miso);
        link_request_t req;
        req.kind = KIND_BIT;
        req.cmd = CMD_W'($urandom);
        req.miso = miso;
        pending_requests.push_back(req);
    endtask

    function automatic logic [CMD_W-1:0] pick_command();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return '1;
        end
        return CMD_W'($urandom);
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_exchange(link_request_t'{s_tuser, s_tdata[CMD_W-1:0], s_tdata[CMD_W]});
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 &&
                    (steady_run || $urandom_range(99) >= 26)) begin
                    next_request = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_request.kind;
                    s_tdata <= {{(S_DATA_W-CMD_W-1){1'b0}}, next_request.miso,
                                next_request.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_result.mosi = m_tdata[0];
                got_result.word = m_tdata[32:1];
                got_result.done = m_tlast;
                got_result.err = m_tuser;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: mosi_bit %0d frame_done %0d",
                           got_result.mosi, got_result.done,
                           " rx_word %h idle_error %0d",
                           got_result.word, got_result.err);
                    errors_seen++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.mosi !== want_result.mosi) begin
                        $error("mosi_bit: expected %0d, got %0d", want_result.mosi, got_result.mosi);
                        errors_seen++;
                    end
                    if (got_result.done !== want_result.done) begin
                        $error("frame_done: expected %0d, got %0d", want_result.done, got_result.done);
                        errors_seen++;
                    end
                    if (got_result.word !== want_result.word) begin
                        $error("rx_word: expected %h, got %h", want_result.word, got_result.word);
                        errors_seen++;
                    end
                    if (got_result.err !== want_result.err) begin
                        $error("idle_error: expected %0d, got %0d", want_result.err, got_result.err);
                        errors_seen++;
                    end
                end
            end
            m_tready <= steady_run || ($urandom_range(99) >= 26);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int counted;
        int pick;
        int n;

        // bit while idle, load extremes, restart while busy
        add_bit(1'b0);
        add_bit(1'b1);
        add_load(24'hFFFFFF);
        add_bit(1'b1);
        add_bit(1'b0);
        add_bit(1'b1);
        add_load(24'h000000);
        add_bit(1'b0);
        add_bit(1'b1);
        add_bit(1'b1);
        add_load(24'h5A3C81);
        add_bit(1'b1);
        add_bit(1'b0);
        add_load(24'h800001);
        add_bit(1'b0);
        add_load(24'h7FFFFE);
        add_bit(1'b1);

        counted = 0;
        while (counted < NUM_REQUESTS) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                add_load(pick_command());
                for (int i = 0; i < FRAME_W; i++) begin
                    add_bit(1'($urandom_range(1)));
                end
                counted += FRAME_W + 1;
                if ($urandom_range(3) == 0) begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) begin
                        add_bit(1'($urandom_range(1)));
                    end
                    counted += n;
                end
            end else if (pick < 92) begin
                add_load(pick_command());
                n = $urandom_range(FRAME_W - 1);
                for (int i = 0; i < n; i++) begin
                    add_bit(1'($urandom_range(1)));
                end
                counted += n + 1;
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(1) == 0) begin
                        add_load(pick_command());
                    end else begin
                        add_bit(1'($urandom_range(1)));
                    end
                end
                counted += n;
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);

        if (errors_seen == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
